>>> sv/hsa_pkg.sv
// shared types and constants for the handle slot allocator
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package hsa_pkg;

    localparam int KEY_W = 10;
    localparam int CNT_W = 11;
    localparam int CNT_MAX = 2047;
    localparam int IN_W = 24;
    localparam int OUT_W = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_QUERY   = 2'd2,
        OP_ITER    = 2'd3
    } op_t;

    // one memory word per slot
    typedef struct packed {
        logic             alive;
        logic [CNT_W-1:0] link;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic scan;
        logic hold_load;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } status_t;

endpackage

>>> sv/hsa_controller.sv
// request sequencer for the handle slot allocator
// depends on hsa_pkg; drives the datapath through cmd_t and reads status_t
`timescale 1ns / 1ps

module hsa_controller
    import hsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  op_t     in_op,
    input  status_t st,
    output logic    s_tready,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // ready resets low and is registered, so it rises only after reset is released
                if (s_tvalid && ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_op == OP_ITER) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = st.out_free ? ST_IDLE : ST_HOLD;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_end)
                begin
                    state_next = st.out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (st.out_free)
                begin
                    cmd.hold_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

>>> sv/hsa_datapath.sv
// slot memory, free-list registers and result register of the allocator
// depends on hsa_pkg; controlled by hsa_controller through cmd_t
`timescale 1ns / 1ps

module hsa_datapath
    import hsa_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  op_t              in_op,
    input  logic [KEY_W-1:0] in_key,
    input  logic [CNT_W-1:0] in_cursor,
    input  cmd_t             cmd,
    output status_t          st,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [KEY_W-1:0] out_key,
    output logic             out_ok,
    output logic [CNT_W-1:0] out_ncur,
    output logic [KEY_W-1:0] out_live
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_LIM = CNT_W'((SLOTS > CNT_MAX) ? CNT_MAX : SLOTS);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    slot_t mem [SLOTS];

    // control state
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             out_valid_reg, out_valid_next;

    // per-request payload
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] cin_reg, cin_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    slot_t            rdata_reg;

    logic [KEY_W-1:0] res_key_reg;
    logic             res_ok_reg;
    logic [CNT_W-1:0] res_ncur_reg;
    logic [KEY_W-1:0] res_live_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic             out_ok_reg;
    logic [CNT_W-1:0] out_ncur_reg;
    logic [KEY_W-1:0] out_live_reg;

    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    slot_t            wr_data;

    logic             finish;
    logic             scan_end;
    logic             out_free;
    logic             load_direct;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] key_ext;
    logic             fresh;
    logic             key_live;
    logic [KEY_W-1:0] res_key;
    logic             res_ok;
    logic [CNT_W-1:0] res_ncur;
    logic [KEY_W-1:0] res_live;

    assign cap_eff  = (cap_reg < SLOTS_LIM) ? cap_reg : SLOTS_LIM;
    assign c0       = (in_cursor == '0) ? ONE : in_cursor;
    assign key_ext  = CNT_W'(key_reg);
    assign fresh    = (free_head_reg >= hw_reg);
    assign key_live = (key_ext != '0) && (key_ext < hw_reg) && rdata_reg.alive;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        free_head_next = free_head_reg;
        hw_next        = hw_reg;
        used_next      = used_reg;
        rd_pend_next   = rd_pend_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        cin_next       = cin_reg;
        cur_next       = cur_reg;
        pend_next      = pend_reg;
        rd_en          = 1'b0;
        rd_addr        = free_head_reg;
        wr_en          = 1'b0;
        wr_addr        = key_ext;
        wr_data        = '0;
        finish         = 1'b0;
        scan_end       = 1'b0;
        res_key        = '0;
        res_ok         = 1'b0;
        res_ncur       = cin_reg;

        if (cmd.accept)
        begin
            op_next      = in_op;
            key_next     = in_key;
            cin_next     = in_cursor;
            rd_pend_next = 1'b0;
            unique case (in_op)
                OP_CREATE:
                begin
                    rd_en   = 1'b1;
                    rd_addr = free_head_reg;
                end
                OP_DESTROY, OP_QUERY:
                begin
                    rd_en   = 1'b1;
                    rd_addr = CNT_W'(in_key);
                end
                OP_ITER:
                begin
                    cur_next = c0;
                    if (c0 < hw_reg)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = c0;
                        pend_next    = c0;
                        cur_next     = c0 + ONE;
                        rd_pend_next = 1'b1;
                    end
                end
                default:
                begin
                    rd_en = 1'b0;
                end
            endcase
        end

        if (cmd.exec)
        begin
            finish = 1'b1;
            unique case (op_reg)
                OP_CREATE:
                begin
                    if (used_reg < cap_eff)
                    begin
                        wr_en         = 1'b1;
                        wr_data.alive = 1'b1;
                        if (fresh)
                        begin
                            wr_addr        = hw_reg;
                            hw_next        = hw_reg + ONE;
                            free_head_next = hw_reg + ONE;
                            res_key        = KEY_W'(hw_reg);
                        end
                        else
                        begin
                            wr_addr        = free_head_reg;
                            free_head_next = rdata_reg.link;
                            res_key        = KEY_W'(free_head_reg);
                        end
                        used_next = used_reg + ONE;
                        res_ok    = 1'b1;
                    end
                end
                OP_DESTROY:
                begin
                    if (key_live)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = key_ext;
                        wr_data.link   = free_head_reg;
                        free_head_next = key_ext;
                        used_next      = used_reg - ONE;
                        res_ok         = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    if (key_live)
                    begin
                        res_key = key_reg;
                        res_ok  = 1'b1;
                    end
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end

        if (cmd.scan)
        begin
            rd_pend_next = 1'b0;
            if (rd_pend_reg && rdata_reg.alive)
            begin
                scan_end = 1'b1;
                res_key  = KEY_W'(pend_reg);
                res_ok   = 1'b1;
                res_ncur = pend_reg + ONE;
            end
            else if (cur_reg < hw_reg)
            begin
                // keep one read in flight so each slot costs one cycle
                rd_en        = 1'b1;
                rd_addr      = cur_reg;
                pend_next    = cur_reg;
                cur_next     = cur_reg + ONE;
                rd_pend_next = 1'b1;
            end
            else
            begin
                scan_end = 1'b1;
                res_ncur = cur_reg;
            end
            finish = scan_end;
        end

        res_live = KEY_W'(used_next - ONE);
    end

    assign load_direct = finish && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_direct || cmd.hold_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            free_head_reg <= ONE;
            hw_reg        <= ONE;
            used_reg      <= ONE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            free_head_reg <= free_head_next;
            hw_reg        <= hw_next;
            used_reg      <= used_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        cin_reg  <= cin_next;
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        if (finish)
        begin
            res_key_reg  <= res_key;
            res_ok_reg   <= res_ok;
            res_ncur_reg <= res_ncur;
            res_live_reg <= res_live;
        end
        if (load_direct)
        begin
            out_key_reg  <= res_key;
            out_ok_reg   <= res_ok;
            out_ncur_reg <= res_ncur;
            out_live_reg <= res_live;
        end
        else if (cmd.hold_load)
        begin
            out_key_reg  <= res_key_reg;
            out_ok_reg   <= res_ok_reg;
            out_ncur_reg <= res_ncur_reg;
            out_live_reg <= res_live_reg;
        end
    end

    // slots one up to below the high-water mark are written before they are read; slot zero is never written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(wr_addr)] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[AW'(rd_addr)];
        end
    end

    assign st.scan_end = scan_end;
    assign st.out_free = out_free;
    assign m_tvalid    = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_ok      = out_ok_reg;
    assign out_ncur    = out_ncur_reg;
    assign out_live    = out_live_reg;

endmodule

>>> sv/handle_slot_allocator.sv
// handle allocator with a lifo free list; slot zero is a reserved stub
// create, destroy and query: the accept reads one slot, then the exec state does the slot
// write, if any, and registers the result; iterate reads the slots it scans with one memory
// read each and spends at least one scan step even when nothing is scanned
// a blocked result holds off the next accept until the output register frees up
// reset (async, active low) clears control state only; the high-water mark bounds the scanned and live slots
`timescale 1ns / 1ps

module handle_slot_allocator
    import hsa_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op[1:0], key[11:2], cursor[22:12], zero pad[23]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // result_key[9:0], ok[10], next_cursor[21:11],
                                        // live_count[31:22]
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    cmd_t             cmd;
    status_t          st;
    op_t              in_op;
    logic [KEY_W-1:0] out_key;
    logic             out_ok;
    logic [CNT_W-1:0] out_ncur;
    logic [KEY_W-1:0] out_live;

    assign in_op = op_t'(s_tdata[1:0]);

    hsa_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_op    (in_op),
        .st       (st),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    hsa_datapath #(
        .SLOTS (SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (in_op),
        .in_key    (s_tdata[11:2]),
        .in_cursor (s_tdata[22:12]),
        .cmd       (cmd),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_key   (out_key),
        .out_ok    (out_ok),
        .out_ncur  (out_ncur),
        .out_live  (out_live)
    );

    assign m_tdata = {out_live, out_ncur, out_ok, out_key};

    // one request at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a failed request never reports a key
    a_fail_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[10] |-> m_tdata[9:0] == '0)
        else $error("nonzero key on a failed result");

    // a result is never loaded while the controller is still starting a request
    a_no_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.exec && !cmd.scan && !cmd.hold_load)
        else $error("result load overlaps request accept");

endmodule

>>> tb/handle_slot_allocator_checker.sv
// checker for the handle slot allocator: watches the request, result and config ports,
// keeps its own copy of the free list and compares every result with the prediction
// depends on hsa_pkg
`timescale 1ns / 1ps

module handle_slot_allocator_checker
    import hsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op[1:0], key[11:2], cursor[22:12], zero pad[23]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // result_key[9:0], ok[10], next_cursor[21:11],
                                        // live_count[31:22]
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);

    localparam int POOL_SLOTS = 1024;

    typedef struct {
        logic [KEY_W-1:0] result_key;
        logic             ok;
        logic [CNT_W-1:0] next_cursor;
        logic [KEY_W-1:0] live_count;
    } alloc_result_t;

    logic [CNT_W-1:0] capacity;
    logic [CNT_W-1:0] slot_link [POOL_SLOTS];
    bit               slot_alive [POOL_SLOTS];
    int               free_head;
    int               high_water;
    int               used_count;
    alloc_result_t    predicted_results [$];

    function automatic bit slot_is_live(input int k);
        return k != 0 && k < high_water && slot_alive[k];
    endfunction

    function automatic alloc_result_t predict_allocation(input op_t op,
                                                         input logic [KEY_W-1:0] key,
                                                         input logic [CNT_W-1:0] cursor);
        alloc_result_t r;
        int            limit;
        int            k;
        int            c;
        r.result_key  = '0;
        r.ok          = 1'b0;
        r.next_cursor = cursor;
        limit = (capacity < POOL_SLOTS) ? int'(capacity) : POOL_SLOTS;
        unique case (op)
            OP_CREATE:
            begin
                if (used_count < limit)
                begin
                    k = free_head;
                    if (k >= high_water)
                    begin
                        // free list exhausted, hand out a fresh slot
                        k = high_water;
                        high_water++;
                        free_head = high_water;
                    end
                    else
                    begin
                        free_head = int'(slot_link[k]);
                    end
                    slot_alive[k] = 1'b1;
                    used_count++;
                    r.result_key = KEY_W'(k);
                    r.ok = 1'b1;
                end
            end
            OP_DESTROY:
            begin
                if (slot_is_live(int'(key)))
                begin
                    slot_link[key]  = CNT_W'(free_head);
                    slot_alive[key] = 1'b0;
                    free_head = int'(key);
                    if (used_count > 0)
                        used_count--;
                    r.ok = 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (slot_is_live(int'(key)))
                begin
                    r.result_key = key;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                c = (cursor == 0) ? 1 : int'(cursor);
                r.next_cursor = CNT_W'(c);
                while (c < high_water)
                begin
                    k = c;
                    c++;
                    r.next_cursor = CNT_W'(c);
                    if (slot_alive[k])
                    begin
                        r.result_key = KEY_W'(k);
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
        endcase
        r.live_count = KEY_W'(used_count - 1);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                slot_link[i]  = '0;
                slot_alive[i] = 1'b0;
            end
            free_head  = 1;
            high_water = 1;
            used_count = 1;   // the stub slot counts as used
            predicted_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("result_key", CNT_W'(want.result_key),
                                  CNT_W'(m_tdata[9:0]));
                    compare_field("ok", CNT_W'(want.ok), CNT_W'(m_tdata[10]));
                    compare_field("next_cursor", want.next_cursor, m_tdata[21:11]);
                    compare_field("live_count", CNT_W'(want.live_count),
                                  CNT_W'(m_tdata[31:22]));
                end
            end
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_tvalid && s_tready)
                predicted_results.push_back(predict_allocation(op_t'(s_tdata[1:0]),
                                                               s_tdata[11:2],
                                                               s_tdata[22:12]));
            pending = predicted_results.size();
        end
    end

endmodule

>>> tb/handle_slot_allocator_test.sv
// top of the handle slot allocator testbench: clock, reset, request stimulus,
// capacity changes and the final verdict
// depends on hsa_pkg, handle_slot_allocator and handle_slot_allocator_checker
`timescale 1ns / 1ps

module handle_slot_allocator_test;
    import hsa_pkg::*;

    localparam int     DRAIN_LIMIT  = 20000;
    localparam longint RUN_LIMIT_NS = 150_000_000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    int               fail_count;
    int               pending;
    bit               calm = 1'b0;
    bit               send_quiet = 1'b0;
    int               stall_left = 0;
    int               seg_left = 0;
    bit               quiet_seg = 1'b1;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    handle_slot_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    handle_slot_allocator_checker alloc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side back-pressure: busy and quiet stretches, with random stall bursts in the busy ones
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_left  = $urandom_range(20, 200);
            quiet_seg = ($urandom_range(0, 2) == 0);
        end
        seg_left--;
        if (calm || quiet_seg)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                                input logic [CNT_W-1:0] cursor);
        if (!calm && !send_quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cursor, key, op};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random requests biased toward a small key range so destroys and queries hit live handles
    task automatic run_phase(input int cap, input int count, input int create_pct,
                             input int key_span);
        int               pick;
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cursor;
        wait_drained();
        write_capacity(CNT_W'(cap));
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < create_pct)
                op = OP_CREATE;
            else
            begin
                pick = $urandom_range(0, 9);
                op = (pick < 4) ? OP_DESTROY : (pick < 7) ? OP_QUERY : OP_ITER;
            end
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(0, 1023))
                                              : KEY_W'($urandom_range(0, key_span));
            cursor = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 2047))
                                                 : CNT_W'($urandom_range(0, key_span + 2));
            send_request(op, key, cursor);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pool: stub key, out of range keys, scans with nothing alive
        send_request(OP_QUERY, 10'd0, 11'd0);
        send_request(OP_DESTROY, 10'd0, 11'd5);
        send_request(OP_QUERY, 10'd1023, 11'd2047);
        send_request(OP_DESTROY, 10'd1023, 11'd0);
        send_request(OP_ITER, 10'd0, 11'd0);
        send_request(OP_ITER, 10'd1023, 11'd2047);
        // fresh keys, then destroy, double destroy and query of a dead key
        send_request(OP_CREATE, 10'd0, 11'd0);
        send_request(OP_CREATE, 10'd1023, 11'd2047);
        send_request(OP_CREATE, 10'd682, 11'd1365);
        send_request(OP_QUERY, 10'd2, 11'd682);
        send_request(OP_DESTROY, 10'd2, 11'd0);
        send_request(OP_DESTROY, 10'd2, 11'd0);
        send_request(OP_QUERY, 10'd2, 11'd0);
        // scans that find a key, skip a dead one and run off the high-water mark
        send_request(OP_ITER, 10'd0, 11'd0);
        send_request(OP_ITER, 10'd0, 11'd2);
        send_request(OP_ITER, 10'd0, 11'd4);
        // reuse from the free list in lifo order, then a fresh key again
        send_request(OP_CREATE, 10'd0, 11'd0);
        send_request(OP_DESTROY, 10'd1, 11'd0);
        send_request(OP_DESTROY, 10'd3, 11'd0);
        send_request(OP_CREATE, 10'd0, 11'd0);
        send_request(OP_CREATE, 10'd0, 11'd0);
        send_request(OP_CREATE, 10'd341, 11'd1023);
        send_request(OP_ITER, 10'd0, 11'd1023);
        send_request(OP_QUERY, 10'd4, 11'd1024);

        // capacity below the live count, below two, above the pool size, a small limit, then back to reset
        run_phase(2, 150, 40, 4);
        run_phase(0, 60, 40, 4);
        run_phase(2047, 450, 55, 300);
        run_phase(17, 300, 35, 40);
        calm = 1'b1;
        run_phase(1024, 500, 35, 400);
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("[handle_slot_allocator] OK");
        else
            $display("[handle_slot_allocator] ERROR");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("[handle_slot_allocator] ERROR");
        $finish;
    end

endmodule
